// ----- sv/rvx_pkg.sv -----
package rvx_pkg;

  localparam int unsigned MEM_BYTES_DEF = 4096;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM32  = 7'b0011011;
  localparam logic [6:0] OP_REG32  = 7'b0111011;
  localparam logic [6:0] F7_ALT    = 7'b0100000;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_POKE,
    CMD_FETCH,
    CMD_DECODE,
    CMD_EXEC,
    CMD_MEM,
    CMD_WB
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_mem;
    logic is_store;
  } stat_t;

endpackage

// ----- sv/rv64i_instruction_executor_unit.sv -----
// RV64I core with a byte-wide program memory. An execute beat raises out_valid
// after a byte-serial fetch, a register read and execute; a store then adds
// byte writes and a load adds byte reads through the single read port plus a
// write-back. A byte-write beat goes straight to its result. out_valid holds
// until out_ready, and in_ready rises again once the result is taken. After
// reset the memory is cleared byte by byte before in_ready rises.
module rv64i_instruction_executor_unit
  import rvx_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_instruction_word,
  output logic [63:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_dest_written,
  output logic        out_unknown_instruction
);

  cmd_t  cmd;
  stat_t stat;

  rvx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  rvx_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_load_address(in_load_address), .in_load_byte(in_load_byte),
    .out_instruction_word(out_instruction_word), .out_next_pc(out_next_pc),
    .out_dest_index(out_dest_index), .out_dest_value(out_dest_value),
    .out_dest_written(out_dest_written),
    .out_unknown_instruction(out_unknown_instruction)
  );

endmodule

// ----- sv/rvx_ram.sv -----
module rvx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rvx_ctrl.sv -----
module rvx_ctrl
  import rvx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_kind,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_WB, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = CMD_NONE;
    cmd.idx   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            state_nxt = S_FETCH;
            cnt_nxt   = '0;
          end else begin
            cmd.op    = CMD_POKE;
            state_nxt = S_OUT;
          end
        end
      end
      S_FETCH: begin
        cmd.op  = CMD_FETCH;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op    = CMD_DECODE;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.op  = CMD_EXEC;
        cnt_nxt = '0;
        if (stat.is_mem) begin
          state_nxt = S_MEM;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MEM: begin
        cmd.op  = CMD_MEM;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          if (stat.is_store) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_WB;
          end
        end
      end
      S_WB: begin
        cmd.op    = CMD_WB;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- sv/rvx_dpath.sv -----
module rvx_dpath
  import rvx_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic [31:0] out_instruction_word,
  output logic [63:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_dest_written,
  output logic        out_unknown_instruction
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [63:0] rf_r [32];
  logic [63:0] pc_r;
  logic [31:0] ir_r;
  logic [63:0] a_r, b_r, val_r, npc_r, ea_r, mdata_r;
  logic        ok_r, wr_r, ld_r, st_r;
  logic [2:0]  f3_r;
  logic [AW-1:0] clr_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [63:0] immi, imms, immb, immu, immj;
  logic [5:0]  shi, shr;
  logic [63:0] a, b, sum_i, sum_r, diff, a32s;
  logic [63:0] val, npc, ea;
  logic        ok, wr, ld, st, taken;
  logic [3:0]  nbytes;
  logic [63:0] ldv;
  logic [63:0] mword;

  assign op = ir_r[6:0];
  assign rd = ir_r[11:7];
  assign f3 = ir_r[14:12];
  assign f7 = ir_r[31:25];
  assign immi = {{52{ir_r[31]}}, ir_r[31:20]};
  assign imms = {{52{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign immb = {{51{ir_r[31]}}, ir_r[31], ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign immu = {{32{ir_r[31]}}, ir_r[31:12], 12'd0};
  assign immj = {{43{ir_r[31]}}, ir_r[31], ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign a = a_r;
  assign b = b_r;
  assign shi = ir_r[25:20];
  assign shr = b_r[5:0];
  assign sum_i = a + immi;
  assign sum_r = a + b;
  assign diff = a - b;
  assign a32s = {{32{a[31]}}, a[31:0]};

  function automatic logic [63:0] sx32(input logic [63:0] v);
    sx32 = {{32{v[31]}}, v[31:0]};
  endfunction

  always_comb begin
    val   = '0;
    npc   = pc_r + 64'd4;
    ok    = 1'b1;
    wr    = 1'b0;
    ld    = 1'b0;
    st    = 1'b0;
    taken = 1'b0;
    ea    = sum_i;
    unique case (op)
      OP_LUI: begin val = immu; wr = 1'b1; end
      OP_AUIPC: begin val = pc_r + immu; wr = 1'b1; end
      OP_JAL: begin val = pc_r + 64'd4; wr = 1'b1; npc = pc_r + immj; end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          ok = 1'b0;
        end else begin
          val = pc_r + 64'd4; wr = 1'b1; npc = {sum_i[63:1], 1'b0};
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = ($signed(a) < $signed(b));
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = (a < b);
          3'd7: taken = (a >= b);
          default: ok = 1'b0;
        endcase
        if (taken) begin
          npc = pc_r + immb;
        end
      end
      OP_LOAD: begin
        wr = 1'b1; ld = 1'b1;
        if (f3 == 3'd7) begin
          ok = 1'b0;
        end
      end
      OP_STORE: begin
        ea = a + imms; st = 1'b1;
        if (f3[2]) begin
          ok = 1'b0;
        end
      end
      OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = sum_i;
          3'd2: val = {63'd0, $signed(a) < $signed(immi)};
          3'd3: val = {63'd0, a < immi};
          3'd4: val = a ^ immi;
          3'd6: val = a | immi;
          3'd7: val = a & immi;
          3'd1: begin
            if (ir_r[31:26] != 6'd0) ok = 1'b0;
            else val = a << shi;
          end
          default: begin
            if (ir_r[31:26] == 6'd0) val = a >> shi;
            else if (ir_r[31:26] == 6'h10) val = $unsigned($signed(a) >>> shi);
            else ok = 1'b0;
          end
        endcase
      end
      OP_REG: begin
        wr = 1'b1;
        if (f7 == F7_ALT) begin
          if (f3 == 3'd0) val = diff;
          else if (f3 == 3'd5) val = $unsigned($signed(a) >>> shr);
          else ok = 1'b0;
        end else if (f7 != 7'd0) begin
          ok = 1'b0;
        end else begin
          case (f3)
            3'd0: val = sum_r;
            3'd1: val = a << shr;
            3'd2: val = {63'd0, $signed(a) < $signed(b)};
            3'd3: val = {63'd0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> shr;
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end
      end
      OP_IMM32: begin
        wr = 1'b1;
        if (f3 == 3'd0) val = sx32(sum_i);
        else if (f3 == 3'd1 && f7 == 7'd0) val = sx32(a << shi[4:0]);
        else if (f3 == 3'd5 && f7 == 7'd0) val = sx32({32'd0, a[31:0]} >> shi[4:0]);
        else if (f3 == 3'd5 && f7 == F7_ALT) val = sx32($unsigned($signed(a32s) >>> shi[4:0]));
        else ok = 1'b0;
      end
      OP_REG32: begin
        wr = 1'b1;
        if (f3 == 3'd0 && f7 == 7'd0) val = sx32(sum_r);
        else if (f3 == 3'd0 && f7 == F7_ALT) val = sx32(diff);
        else if (f3 == 3'd1 && f7 == 7'd0) val = sx32(a << shr[4:0]);
        else if (f3 == 3'd5 && f7 == 7'd0) val = sx32({32'd0, a[31:0]} >> shr[4:0]);
        else if (f3 == 3'd5 && f7 == F7_ALT) val = sx32($unsigned($signed(a32s) >>> shr[4:0]));
        else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
  end

  assign nbytes = 4'd1 << f3_r[1:0];

  assign mword = (cmd.op == CMD_WB) ? {rdata, mdata_r[55:0]} : mdata_r;

  always_comb begin
    unique case (f3_r)
      3'd0: ldv = {{56{mword[7]}}, mword[7:0]};
      3'd1: ldv = {{48{mword[15]}}, mword[15:0]};
      3'd2: ldv = {{32{mword[31]}}, mword[31:0]};
      3'd4: ldv = {56'd0, mword[7:0]};
      3'd5: ldv = {48'd0, mword[15:0]};
      3'd6: ldv = {32'd0, mword[31:0]};
      default: ldv = mword;
    endcase
  end

  logic [AW-1:0] pc_base, ea_base;
  assign pc_base = pc_r[AW-1:0] + AW'(cmd.idx);
  assign ea_base = ea_r[AW-1:0] + AW'(cmd.idx);

  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = '0;
    raddr = pc_base;
    case (cmd.op)
      CMD_CLEAR: we = 1'b1;
      CMD_POKE: begin
        we = 1'b1; waddr = AW'(in_load_address % MEM_BYTES); wdata = in_load_byte;
      end
      CMD_MEM: begin
        raddr = ea_base;
        waddr = ea_base;
        wdata = b_r[8*cmd.idx +: 8];
        we    = st_r && ({1'b0, cmd.idx} < nbytes);
      end
      default: ;
    endcase
  end

  assign stat.clear_done = (clr_r == AW'(MEM_BYTES - 1));
  assign stat.is_mem     = ok && (ld || st);
  assign stat.is_store   = st_r;

  logic [2:0] pidx;
  assign pidx = cmd.idx - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      pc_r  <= '0;
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else begin
      case (cmd.op)
        CMD_CLEAR: clr_r <= clr_r + AW'(1);
        CMD_POKE: begin
          ir_r <= '0; ok_r <= 1'b1; wr_r <= 1'b0; ld_r <= 1'b0; npc_r <= pc_r;
        end
        CMD_FETCH: begin
          if (cmd.idx != 3'd0) ir_r[8*pidx[1:0] +: 8] <= rdata;
        end
        CMD_DECODE: begin
          a_r <= (ir_r[19:15] == 5'd0) ? 64'd0 : rf_r[ir_r[19:15]];
          b_r <= (ir_r[24:20] == 5'd0) ? 64'd0 : rf_r[ir_r[24:20]];
        end
        CMD_EXEC: begin
          ok_r <= ok; wr_r <= wr && ok && (rd != 5'd0); ld_r <= ld; st_r <= st && ok;
          f3_r <= f3; val_r <= val; npc_r <= ok ? npc : pc_r; ea_r <= ea;
          if (ok) pc_r <= npc;
          if (ok && !ld && wr && rd != 5'd0) rf_r[rd] <= val;
        end
        CMD_MEM: begin
          if (cmd.idx != 3'd0) mdata_r[8*pidx +: 8] <= rdata;
        end
        CMD_WB: begin
          mdata_r[63:56] <= rdata;
          if (ld_r && rd != 5'd0) rf_r[rd] <= ldv;
        end
        default: ;
      endcase
    end
  end

  logic [63:0] fullv;
  assign fullv = (f3_r == 3'd3) ? mdata_r : ldv;

  assign out_instruction_word    = ir_r;
  assign out_next_pc             = npc_r;
  assign out_dest_written        = ok_r && wr_r;
  assign out_dest_index          = (ok_r && wr_r) ? rd : 5'd0;
  assign out_dest_value          = !(ok_r && wr_r) ? 64'd0 : (ld_r ? fullv : val_r);
  assign out_unknown_instruction = !ok_r;

endmodule

// ----- sv/rvx_checker.sv -----
module rvx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_dest_written,
  input logic [4:0]  out_dest_index,
  input logic        out_unknown_instruction
);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dest_written |-> out_dest_index != 5'd0)
    else $error("write to x0 reported");

  a_unk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_instruction |-> !out_dest_written)
    else $error("unknown op wrote register");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("input beat withdrawn");

endmodule

bind rv64i_instruction_executor_unit rvx_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_dest_written(out_dest_written), .out_dest_index(out_dest_index),
  .out_unknown_instruction(out_unknown_instruction)
);
